// ===== rtl/core/ansg_pkg.sv =====
// ----------------------------------------------------------------------------
// ansg_pkg: shared types and constants for the SGR color parser
// Byte codes, phase encoding, token and pending-attribute records, and the
// decoder that classifies a finished parameter token.
// ----------------------------------------------------------------------------
package ansg_pkg;

   localparam int BUFFER_LIMIT = 16;
   localparam int HELD_W       = $clog2(BUFFER_LIMIT + 1);

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // token values above the largest code collapse to all ones
   localparam int              TOKEN_W   = 6;
   localparam int              CODE_MAX  = 47;
   localparam logic [TOKEN_W-1:0] TOKEN_SAT = '1;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_M        = 8'h6D;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;

   localparam logic [TOKEN_W-1:0] SGR_FG_BASE = 6'd30;
   localparam logic [TOKEN_W-1:0] SGR_FG_LAST = 6'd37;
   localparam logic [TOKEN_W-1:0] SGR_BG_BASE = 6'd40;
   localparam logic [TOKEN_W-1:0] SGR_BG_LAST = 6'd47;
   localparam logic [TOKEN_W-1:0] SGR_CLEAR   = 6'd0;
   localparam logic [TOKEN_W-1:0] SGR_BOLDEN  = 6'd1;

   typedef logic signed [3:0] color_type;
   localparam color_type COLOR_DEFAULT = -4'sd1;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_TYPE = 2'd1,
      PH_SEQ  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      SGR_NONE,
      SGR_RESET,
      SGR_BOLD,
      SGR_FG,
      SGR_BG
   } sgr_code_type;

   typedef struct packed {
      logic [TOKEN_W-1:0] value;
      logic               started;
      logic               bad;
   } token_type;

   typedef struct packed {
      color_type fg;
      color_type bg;
      logic      bold;
      logic      stopped;
   } pending_type;

   typedef struct packed {
      color_type fg;
      color_type bg;
      logic      bold;
      logic      done;
   } result_type;

   function automatic sgr_code_type sgr_decode(input logic [TOKEN_W-1:0] value);
      sgr_code_type code;
      if (value == SGR_CLEAR) begin
         code = SGR_RESET;
      end else if (value == SGR_BOLDEN) begin
         code = SGR_BOLD;
      end else if (value >= SGR_FG_BASE && value <= SGR_FG_LAST) begin
         code = SGR_FG;
      end else if (value >= SGR_BG_BASE && value <= SGR_BG_LAST) begin
         code = SGR_BG;
      end else begin
         code = SGR_NONE;
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/ansg_token.sv =====
// ----------------------------------------------------------------------------
// ansg_token: parameter token accumulate and finish logic
// Folds one held byte into the running token, and works out what the
// pending attributes become when the current token ends.
// ----------------------------------------------------------------------------
module ansg_token (
   input  logic [7:0]           in_byte,
   input  ansg_pkg::token_type   tok_ff,
   input  ansg_pkg::pending_type pend_ff,
   output ansg_pkg::token_type   tok_acc,
   output ansg_pkg::pending_type pend_fin
);
   import ansg_pkg::*;

   logic [3:0]         digit;
   logic               is_digit;
   logic [8:0]         prod;
   logic [TOKEN_W-1:0] diff_fg;
   logic [TOKEN_W-1:0] diff_bg;
   sgr_code_type       code;

   assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
   assign digit    = 4'(in_byte - CH_ZERO);
   assign prod     = {3'b000, tok_ff.value} * 9'd10 + {5'b00000, digit};

   always_comb begin
      tok_acc         = tok_ff;
      tok_acc.started = 1'b1;
      if (!is_digit) begin
         tok_acc.bad = 1'b1;
      end else if (tok_ff.value > TOKEN_W'(CODE_MAX) || prod > 9'(CODE_MAX)) begin
         tok_acc.value = TOKEN_SAT;
      end else begin
         tok_acc.value = prod[TOKEN_W-1:0];
      end
   end

   assign code    = sgr_decode(tok_ff.value);
   assign diff_fg = tok_ff.value - SGR_FG_BASE;
   assign diff_bg = tok_ff.value - SGR_BG_BASE;

   always_comb begin
      pend_fin = pend_ff;
      if (tok_ff.started && !pend_ff.stopped) begin
         if (tok_ff.bad) begin
            pend_fin.fg      = COLOR_DEFAULT;
            pend_fin.bg      = COLOR_DEFAULT;
            pend_fin.stopped = 1'b1;
         end else begin
            unique case (code)
               SGR_RESET: begin
                  pend_fin.fg = COLOR_DEFAULT;
                  pend_fin.bg = COLOR_DEFAULT;
               end
               SGR_FG:   pend_fin.fg   = {1'b0, diff_fg[2:0]};
               SGR_BG:   pend_fin.bg   = {1'b0, diff_bg[2:0]};
               SGR_BOLD: pend_fin.bold = 1'b1;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== rtl/core/ansg_parser.sv =====
// ----------------------------------------------------------------------------
// ansg_parser: escape sequence state machine and attribute registers
// Tracks ESC [ ... m framing, the held byte count, the running token and the
// pending and committed attributes; gives the attributes after each byte.
// ----------------------------------------------------------------------------
module ansg_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           in_byte,
   output ansg_pkg::result_type result
);
   import ansg_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [HELD_W-1:0]  held_ff, held_in, held_inc;
   token_type          tok_ff, tok_in, tok_acc;
   pending_type        pend_ff, pend_in, pend_fin;
   color_type          fg_now_ff, fg_now_in;
   color_type          bg_now_ff, bg_now_in;
   logic               bold_now_ff, bold_now_in;
   logic               done;

   ansg_token u_token (
      .in_byte  (in_byte),
      .tok_ff   (tok_ff),
      .pend_ff  (pend_ff),
      .tok_acc  (tok_acc),
      .pend_fin (pend_fin)
   );

   assign held_inc = held_ff + HELD_W'(1);

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_TYPE: phase_in = (in_byte == CH_LBRACKET) ? PH_SEQ : PH_WAIT;
            PH_SEQ: begin
               if (in_byte == CH_M) begin
                  phase_in = PH_WAIT;
               end else if (held_inc >= HELD_W'(BUFFER_LIMIT)) begin
                  phase_in = PH_WAIT;
               end else begin
                  phase_in = PH_SEQ;
               end
            end
            default: phase_in = (in_byte == CH_ESC) ? PH_TYPE : PH_WAIT;
         endcase
      end
   end

   always_comb begin
      held_in     = held_ff;
      tok_in      = tok_ff;
      pend_in     = pend_ff;
      fg_now_in   = fg_now_ff;
      bg_now_in   = bg_now_ff;
      bold_now_in = bold_now_ff;
      done        = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (in_byte == CH_LBRACKET) begin
                  held_in = '0;
                  tok_in  = '0;
                  pend_in = '{fg: fg_now_ff, bg: bg_now_ff, bold: bold_now_ff,
                              stopped: 1'b0};
               end
            end
            PH_SEQ: begin
               if (in_byte == CH_M) begin
                  tok_in      = '0;
                  pend_in     = pend_fin;
                  fg_now_in   = pend_fin.fg;
                  bg_now_in   = pend_fin.bg;
                  bold_now_in = bold_now_ff | pend_fin.bold;
                  done        = 1'b1;
               end else if (in_byte == CH_SEMI) begin
                  tok_in  = '0;
                  pend_in = pend_fin;
                  held_in = held_inc;
               end else begin
                  tok_in  = tok_acc;
                  held_in = held_inc;
               end
            end
            default: ;
         endcase
      end
   end

   assign result = '{fg: fg_now_in, bg: bg_now_in, bold: bold_now_in, done: done};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         held_ff     <= '0;
         tok_ff      <= '0;
         pend_ff     <= '{fg: COLOR_DEFAULT, bg: COLOR_DEFAULT, bold: 1'b0,
                          stopped: 1'b0};
         fg_now_ff   <= COLOR_DEFAULT;
         bg_now_ff   <= COLOR_DEFAULT;
         bold_now_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         tok_ff      <= tok_in;
         pend_ff     <= pend_in;
         fg_now_ff   <= fg_now_in;
         bg_now_ff   <= bg_now_in;
         bold_now_ff <= bold_now_in;
      end
   end

endmodule

// ===== rtl/core/ansg_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// ansg_rsp_reg: result output register
// Holds one result word for the downstream side; takes a new word in the
// same cycle that the held one leaves.
// ----------------------------------------------------------------------------
module ansg_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ansg_pkg::result_type load_data,
   input  logic                 out_ready,
   output logic                 out_valid,
   output ansg_pkg::result_type out_data,
   output logic                 can_load
);
   import ansg_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/ansi_sgr_color_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser: SGR color attribute tracker
// Follows ESC [ params m sequences in a byte stream and reports the current
// foreground, background and bold attributes after every byte.
//
//   channel  dir  word                      use
//   req_     in   tdata[7:0] in_byte        terminal stream byte
//   rsp_     out  tdata[9:0] attrs + done   one word per byte taken
//
// One word per cycle while rsp_tready stays high; each result appears in the cycle after its byte is taken.
// The result word is held in the single output register stage, ansg_rsp_reg.
// req_tready drops only while a result word waits on rsp_tready low.
// Synchronous reset returns to waiting for ESC with default colors, bold off.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ansg_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] in_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ansg_pkg::RSP_DATA_W-1:0]     rsp_tdata   // [3:0] fg_color,
                                                           // [7:4] bg_color,
                                                           // [8] bold_on,
                                                           // [9] sequence_done
);
   import ansg_pkg::*;

   logic       fire;
   logic       can_load;
   result_type result;
   result_type rsp_word;

   assign req_tready = can_load;
   assign fire       = req_tvalid && can_load;

   ansg_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (req_tdata[7:0]),
      .result  (result)
   );

   ansg_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_word),
      .can_load  (can_load)
   );

   assign rsp_tdata = {6'b000000, rsp_word.done, rsp_word.bold,
                       rsp_word.bg, rsp_word.fg};

endmodule

// ===== rtl/core/ansg_checker.sv =====
// ----------------------------------------------------------------------------
// ansg_checker: port-level checks for the SGR color parser
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ansg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [ansg_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ansg_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ansg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no rsp word after req word");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req taken while rsp word stalled");

   a_done_on_m: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata != CH_M |=> !rsp_tdata[9])
      else $error("sequence_done without closing byte");

   a_bold_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |=> !rsp_tvalid || rsp_tdata[8])
      else $error("bold cleared");

endmodule

bind ansi_sgr_color_parser ansg_checker u_ansg_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the SGR color parser
// Streams terminal bytes into the parser and compares every result word with a
// local model of the escape-sequence tracker. The stream opens with a short
// table of hand-checked bytes, then mixes SGR sequences with random tokens,
// noise, broken escapes and buffer overruns. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
   import ansg_pkg::*;

   localparam int          ITEM_TARGET  = 1200;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          LATENCY_TAIL = 8;
   localparam int          IDLE_PCT     = 10;
   localparam int          HOLD_START   = 600;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          RX_BUSY_LO   = 900;
   localparam int          RX_BUSY_HI   = 1200;
   localparam int          TX_BUSY_LO   = 300;
   localparam int          TX_BUSY_HI   = 600;
   localparam int          MAX_REPORTS  = 40;
   localparam logic [31:0] VALUE_CEIL   = 32'h7FFF_FFFF;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef struct packed {
      logic [7:0] value;
      logic       typed;
      color_type  fg;
      color_type  bg;
      logic       bold;
      logic       done;
   } stim_row_type;

   localparam color_type DEF = COLOR_DEFAULT;

   localparam stim_row_type OPENING_ROWS [25] = '{
      '{8'h00,       1'b1, DEF,   DEF,   1'b0, 1'b0},
      '{8'hFF,       1'b1, DEF,   DEF,   1'b0, 1'b0},
      '{CH_ESC,      1'b1, DEF,   DEF,   1'b0, 1'b0},
      '{CH_LBRACKET, 1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{"3",         1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{"7",         1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_SEMI,     1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{"4",         1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{"0",         1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_SEMI,     1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{"1",         1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_M,        1'b1, 4'sd7, 4'sd0, 1'b1, 1'b1},
      '{CH_ESC,      1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_ESC,      1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_LBRACKET, 1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_M,        1'b1, 4'sd7, 4'sd0, 1'b1, 1'b0},
      '{CH_ESC,      1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_LBRACKET, 1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_SEMI,     1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_PLUS,     1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{"3",         1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_SEMI,     1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{"3",         1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{"1",         1'b0, DEF,   DEF,   1'b0, 1'b0},
      '{CH_M,        1'b1, DEF,   DEF,   1'b1, 1'b1}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   stim_row_type byte_stream_q [$];
   result_type   attr_expect_q [$];

   int noise_cnt   = 0;
   int send_idx    = 0;
   int taken_cnt   = 0;
   int got_cnt     = 0;
   int err_cnt     = 0;
   int closed_cnt  = 0;
   int overrun_cnt = 0;
   int quiet_cnt   = 0;
   int rx_cycle    = 0;
   int hold_left   = 0;
   int drain_at    = 0;

   phase_type   ph;
   int unsigned held;
   logic [31:0] tok;
   logic        tok_started, tok_bad, seq_stopped;
   color_type   pend_fg, pend_bg, cur_fg, cur_bg;
   logic        pend_bold, cur_bold;

   always #1 clock = ~clock;

   ansi_sgr_color_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic void clear_token();
      tok         = '0;
      tok_started = 1'b0;
      tok_bad     = 1'b0;
   endfunction

   function automatic void mirror_reset();
      ph          = PH_WAIT;
      held        = 0;
      clear_token();
      seq_stopped = 1'b0;
      pend_fg     = COLOR_DEFAULT;
      pend_bg     = COLOR_DEFAULT;
      pend_bold   = 1'b0;
      cur_fg      = COLOR_DEFAULT;
      cur_bg      = COLOR_DEFAULT;
      cur_bold    = 1'b0;
   endfunction

   function automatic void close_token();
      if (tok_started && !seq_stopped) begin
         if (tok_bad) begin
            pend_fg     = COLOR_DEFAULT;
            pend_bg     = COLOR_DEFAULT;
            seq_stopped = 1'b1;
         end else if (tok == SGR_CLEAR) begin
            pend_fg = COLOR_DEFAULT;
            pend_bg = COLOR_DEFAULT;
         end else if (tok >= SGR_FG_BASE && tok <= SGR_FG_LAST) begin
            pend_fg = color_type'(tok - SGR_FG_BASE);
         end else if (tok >= SGR_BG_BASE && tok <= SGR_BG_LAST) begin
            pend_bg = color_type'(tok - SGR_BG_BASE);
         end else if (tok == SGR_BOLDEN) begin
            pend_bold = 1'b1;
         end
      end
      clear_token();
   endfunction

   function automatic result_type advance_parser(input logic [7:0] b);
      logic [31:0] d;
      result_type  r;
      r.done = 1'b0;
      case (ph)
         PH_TYPE: begin
            if (b == CH_LBRACKET) begin
               ph          = PH_SEQ;
               held        = 0;
               clear_token();
               seq_stopped = 1'b0;
               pend_fg     = cur_fg;
               pend_bg     = cur_bg;
               pend_bold   = cur_bold;
            end else begin
               ph = PH_WAIT;
            end
         end
         PH_SEQ: begin
            if (b == CH_M) begin
               close_token();
               cur_fg   = pend_fg;
               cur_bg   = pend_bg;
               cur_bold = cur_bold | pend_bold;
               r.done   = 1'b1;
               ph       = PH_WAIT;
               closed_cnt++;
            end else begin
               if (b == CH_SEMI) begin
                  close_token();
               end else begin
                  tok_started = 1'b1;
                  if (b >= CH_ZERO && b <= CH_NINE) begin
                     d = 32'(b - CH_ZERO);
                     if (tok > (VALUE_CEIL - d) / 10) tok = VALUE_CEIL;
                     else tok = tok * 10 + d;
                  end else begin
                     tok_bad = 1'b1;
                  end
               end
               held++;
               if (held >= BUFFER_LIMIT) begin
                  ph = PH_WAIT;
                  overrun_cnt++;
               end
            end
         end
         default: ph = (b == CH_ESC) ? PH_TYPE : PH_WAIT;
      endcase
      r.fg   = cur_fg;
      r.bg   = cur_bg;
      r.bold = cur_bold;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int seen_v, input int want_v);
      if (err_cnt < MAX_REPORTS)
         $display("mismatch at word %0d: %s got %0d expected %0d", got_cnt, what, seen_v, want_v);
      err_cnt++;
   endtask

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_non_digit();
      logic [7:0] b;
      case ($urandom_range(0, 4))
         0: b = CH_SPACE;
         1: b = CH_PLUS;
         2: b = CH_MINUS;
         3: b = CH_NUL;
         default: begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_M);
         end
      endcase
      return b;
   endfunction

   task automatic put(input logic [7:0] b);
      byte_stream_q.insert(byte_stream_q.size(), '{b, 1'b0, DEF, DEF, 1'b0, 1'b0});
   endtask

   task automatic put_decimal(input int unsigned v);
      logic [7:0] digits [$];
      do begin
         digits.push_front(CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) put(digits[i]);
   endtask

   task automatic put_token();
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         case ($urandom_range(0, 3))
            0: put_decimal($urandom_range(0, 1));
            1: put_decimal($urandom_range(30, 37));
            2: put_decimal($urandom_range(40, 47));
            default: begin
               put(CH_ZERO);
               put_decimal($urandom_range(30, 47));
            end
         endcase
      end else if (kind < 58) begin
         put_decimal($urandom_range(0, 99));
      end else if (kind < 72) begin
         repeat ($urandom_range(0, 2)) put(rand_digit());
         put(pick_non_digit());
         repeat ($urandom_range(0, 2)) put(rand_digit());
      end else if (kind < 82) begin
         repeat ($urandom_range(10, 12)) put(rand_digit());
      end else if (kind < 90) begin
         put_decimal($urandom_range(100, 65535));
      end
   endtask

   task automatic put_sequence();
      int unsigned ntok;
      ntok = $urandom_range(0, 4);
      put(CH_ESC);
      put(CH_LBRACKET);
      for (int i = 0; i < ntok; i++) begin
         if (i != 0) put(CH_SEMI);
         put_token();
      end
      if ($urandom_range(0, 99) < 6)
         repeat (BUFFER_LIMIT) put($urandom_range(0, 3) == 0 ? CH_SEMI : rand_digit());
      put(CH_M);
   endtask

   task automatic put_broken();
      put(CH_ESC);
      if ($urandom_range(0, 1) == 0) begin
         put(pick_non_digit());
      end else begin
         put(CH_LBRACKET);
         put_token();
      end
   endtask

   task automatic put_noise();
      int unsigned n;
      n = $urandom_range(1, 6);
      repeat (n) put(8'($urandom_range(0, 255)));
      noise_cnt += n;
   endtask

   task automatic build_stream();
      int unsigned pick;
      foreach (OPENING_ROWS[i]) byte_stream_q.insert(byte_stream_q.size(), OPENING_ROWS[i]);
      while (byte_stream_q.size() - noise_cnt < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) put_sequence();
         else if (pick < 88) put_noise();
         else put_broken();
      end
      drain_at = byte_stream_q.size() * 3 / 4;
   endtask

   always @(posedge clock) begin
      result_type   want;
      result_type   seen;
      stim_row_type row;
      logic         idle;
      if (reset) begin
         mirror_reset();
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = advance_parser(req_tdata);
            row  = byte_stream_q[taken_cnt];
            if (row.typed) want = '{row.fg, row.bg, row.bold, row.done};
            attr_expect_q.insert(attr_expect_q.size(), want);
            taken_cnt++;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.fg   = rsp_tdata[3:0];
            seen.bg   = rsp_tdata[7:4];
            seen.bold = rsp_tdata[8];
            seen.done = rsp_tdata[9];
            if (attr_expect_q.size() == 0) begin
               report_mismatch("unexpected word, fg", int'(seen.fg), 0);
            end else begin
               want = attr_expect_q.pop_front();
               if (seen.fg !== want.fg) report_mismatch("fg_color", int'(seen.fg), int'(want.fg));
               if (seen.bg !== want.bg) report_mismatch("bg_color", int'(seen.bg), int'(want.bg));
               if (seen.bold !== want.bold)
                  report_mismatch("bold_on", int'(seen.bold), int'(want.bold));
               if (seen.done !== want.done)
                  report_mismatch("sequence_done", int'(seen.done), int'(want.done));
            end
            got_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            idle = !(send_idx >= TX_BUSY_LO && send_idx < TX_BUSY_HI)
                   && $urandom_range(0, 99) < IDLE_PCT;
            // hold here once until every outstanding word has come back
            if (send_idx == drain_at && (taken_cnt != send_idx || attr_expect_q.size() != 0))
               idle = 1'b1;
            if (send_idx < byte_stream_q.size() && !idle) begin
               req_tvalid <= 1'b1;
               req_tdata  <= byte_stream_q[send_idx].value;
               send_idx++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycle   <= 0;
         hold_left  <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle == HOLD_START) begin
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (rx_cycle >= RX_BUSY_LO && rx_cycle < RX_BUSY_HI) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cnt <= 0;
      end else if (quiet_cnt >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d words still expected",
                  quiet_cnt, attr_expect_q.size());
         $display("FAIL ansi_sgr_color_parser");
         $finish;
      end else begin
         quiet_cnt <= quiet_cnt + 1;
      end
   end

   initial begin
      build_stream();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (taken_cnt < byte_stream_q.size() || attr_expect_q.size() != 0) @(posedge clock);
      repeat (LATENCY_TAIL) @(posedge clock);
      $display("run covered %0d bytes (%0d noise), %0d result words checked",
               taken_cnt, noise_cnt, got_cnt);
      $display("sequences closed %0d, overruns dropped %0d, mismatches %0d",
               closed_cnt, overrun_cnt, err_cnt);
      if (err_cnt == 0) $display("PASS ansi_sgr_color_parser");
      else $display("FAIL ansi_sgr_color_parser");
      $finish;
   end

endmodule

// ===== ansi_sgr_color_parser.f =====
rtl/core/ansg_pkg.sv
rtl/core/ansg_token.sv
rtl/core/ansg_parser.sv
rtl/core/ansg_rsp_reg.sv
rtl/core/ansi_sgr_color_parser.sv
rtl/core/ansg_checker.sv
tb/sv/tb.sv
